[hdl/press_count_confirm_blink_sequencer_defines.svh]
// Assertion macros shared by the press-count confirm and blink sequencer.
`ifndef PRESS_COUNT_CONFIRM_BLINK_SEQUENCER_DEFINES_SVH
`define PRESS_COUNT_CONFIRM_BLINK_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define PCCBS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pccbs assertion failed");
`define PCCBS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pccbs assertion failed");
`else
`define PCCBS_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define PCCBS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

[hdl/pccbs_pkg.sv]
// Types and constants of the press-count confirm and blink sequencer.
package pccbs_pkg;

	localparam int TICK_W   = 16;
	localparam int COUNT_W  = 5;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [COUNT_W-1:0] COUNT_MIN = 5'd1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd19;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_KEY  = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_ON_TICKS      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFF_TICKS     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PAUSE_TICKS   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CONFIRM_TICKS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LED_OFF_LEVEL = 3'd4;

	localparam logic [TICK_W-1:0] ON_TICKS_RST      = 16'd150;
	localparam logic [TICK_W-1:0] OFF_TICKS_RST     = 16'd150;
	localparam logic [TICK_W-1:0] PAUSE_TICKS_RST   = 16'd1000;
	localparam logic [TICK_W-1:0] CONFIRM_TICKS_RST = 16'd5000;
	localparam logic              LED_OFF_LEVEL_RST = 1'b0;

	typedef struct packed {
		logic [TICK_W-1:0] on_ticks;
		logic [TICK_W-1:0] off_ticks;
		logic [TICK_W-1:0] pause_ticks;
		logic [TICK_W-1:0] confirm_ticks;
		logic              led_off_level;
	} cfg_t;

	typedef struct packed {
		logic               led_level;
		logic               led_owned;
		logic               save_valid;
		logic               save_target;
		logic [COUNT_W-1:0] save_count;
	} result_t;

endpackage

[hdl/pccbs_regs.sv]
// Configuration register file with its APB-style access port.
module pccbs_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pccbs_pkg::PADDR_W-1:0]  paddr,
	input  logic [pccbs_pkg::PDATA_W-1:0]  pwdata,
	output logic [pccbs_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready,
	output pccbs_pkg::cfg_t                cfg
);
	import pccbs_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_ticks      <= ON_TICKS_RST;
			cfg_q.off_ticks     <= OFF_TICKS_RST;
			cfg_q.pause_ticks   <= PAUSE_TICKS_RST;
			cfg_q.confirm_ticks <= CONFIRM_TICKS_RST;
			cfg_q.led_off_level <= LED_OFF_LEVEL_RST;
		end else if (wr_en) begin
			case (idx)
				REG_ON_TICKS:      cfg_q.on_ticks      <= pwdata[TICK_W-1:0];
				REG_OFF_TICKS:     cfg_q.off_ticks     <= pwdata[TICK_W-1:0];
				REG_PAUSE_TICKS:   cfg_q.pause_ticks   <= pwdata[TICK_W-1:0];
				REG_CONFIRM_TICKS: cfg_q.confirm_ticks <= pwdata[TICK_W-1:0];
				REG_LED_OFF_LEVEL: cfg_q.led_off_level <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ON_TICKS:      prdata = {{(PDATA_W-TICK_W){1'b0}}, cfg_q.on_ticks};
			REG_OFF_TICKS:     prdata = {{(PDATA_W-TICK_W){1'b0}}, cfg_q.off_ticks};
			REG_PAUSE_TICKS:   prdata = {{(PDATA_W-TICK_W){1'b0}}, cfg_q.pause_ticks};
			REG_CONFIRM_TICKS: prdata = {{(PDATA_W-TICK_W){1'b0}}, cfg_q.confirm_ticks};
			REG_LED_OFF_LEVEL: prdata = {{(PDATA_W-1){1'b0}}, cfg_q.led_off_level};
			default:           prdata = '0;
		endcase
	end

endmodule

[hdl/pccbs_core.sv]
// Sequencer state with the per-transaction confirm and blink update.
`include "press_count_confirm_blink_sequencer_defines.svh"

module pccbs_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           mode,
	input  logic                           key_target,
	input  logic [pccbs_pkg::COUNT_W-1:0]  press_count,
	input  pccbs_pkg::cfg_t                cfg,
	output pccbs_pkg::result_t             res
);
	import pccbs_pkg::*;

	logic               pending_q, pending_d;
	logic               target_kind_q, target_kind_d;
	logic [COUNT_W-1:0] armed_count_q, armed_count_d;
	logic [COUNT_W-1:0] blinks_done_q, blinks_done_d;
	logic               lit_q, lit_d;
	logic [TICK_W-1:0]  phase_left_q, phase_left_d;
	logic [TICK_W-1:0]  confirm_left_q, confirm_left_d;
	logic [TICK_W-1:0]  confirm_dec;
	logic [TICK_W-1:0]  phase_dec;
	logic               count_ok;

	assign count_ok    = press_count inside {[COUNT_MIN:COUNT_MAX]};
	assign confirm_dec = (confirm_left_q == '0) ? '0 : confirm_left_q - TICK_W'(1);
	assign phase_dec   = (phase_left_q == '0) ? '0 : phase_left_q - TICK_W'(1);

	always_comb begin
		pending_d       = pending_q;
		target_kind_d   = target_kind_q;
		armed_count_d   = armed_count_q;
		blinks_done_d   = blinks_done_q;
		lit_d           = lit_q;
		phase_left_d    = phase_left_q;
		confirm_left_d  = confirm_left_q;
		res.save_valid  = 1'b0;
		res.save_target = 1'b0;
		res.save_count  = '0;
		if (step) begin
			if (mode == MODE_KEY) begin
				if (count_ok) begin
					pending_d      = 1'b1;
					target_kind_d  = key_target;
					armed_count_d  = press_count;
					confirm_left_d = cfg.confirm_ticks;
					blinks_done_d  = '0;
					lit_d          = 1'b1;
					phase_left_d   = cfg.on_ticks;
				end
			end else if (pending_q) begin
				confirm_left_d = confirm_dec;
				if (confirm_dec == '0) begin
					res.save_valid  = 1'b1;
					res.save_target = target_kind_q;
					res.save_count  = armed_count_q;
					pending_d       = 1'b0;
				end else begin
					phase_left_d = phase_dec;
					if (phase_dec == '0) begin
						if (lit_q) begin
							lit_d         = 1'b0;
							blinks_done_d = blinks_done_q + COUNT_W'(1);
							phase_left_d  = cfg.off_ticks;
						end else if (blinks_done_q >= armed_count_q) begin
							blinks_done_d = '0;
							phase_left_d  = cfg.pause_ticks;
						end else begin
							lit_d        = 1'b1;
							phase_left_d = cfg.on_ticks;
						end
					end
				end
			end
		end
		res.led_owned = pending_d;
		res.led_level = (pending_d && lit_d) ? ~cfg.led_off_level : cfg.led_off_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q      <= 1'b0;
			target_kind_q  <= 1'b0;
			armed_count_q  <= '0;
			blinks_done_q  <= '0;
			lit_q          <= 1'b0;
			phase_left_q   <= '0;
			confirm_left_q <= '0;
		end else begin
			pending_q      <= pending_d;
			target_kind_q  <= target_kind_d;
			armed_count_q  <= armed_count_d;
			blinks_done_q  <= blinks_done_d;
			lit_q          <= lit_d;
			phase_left_q   <= phase_left_d;
			confirm_left_q <= confirm_left_d;
		end
	end

	`PCCBS_ASSERT_NOW(a_armed_in_range, clk, arst_n, pending_q, (armed_count_q >= COUNT_MIN) && (armed_count_q <= COUNT_MAX))
	`PCCBS_ASSERT_NOW(a_blinks_bounded, clk, arst_n, pending_q, blinks_done_q <= armed_count_q)
	`PCCBS_ASSERT_NEXT(a_expiry_clears, clk, arst_n, step && (mode == MODE_TICK) && pending_q && (confirm_left_q <= TICK_W'(1)), !pending_q)

endmodule

[hdl/press_count_confirm_blink_sequencer.sv]
// Top level of the press-count confirm and blink sequencer.
//
// Takes one transaction per clock while item_stall is low: a tick or a key
// result. Each accepted transaction gives exactly one result, through the
// input register and then the result register. The confirm and blink
// counters are updated between the input register and the result register.
// The result register frees the input side: while a result waits under
// stall, one more transaction is still taken into the input register. The
// user writes configuration registers over the APB-style port only while no
// transaction is in flight; the block itself does not enforce this.
module press_count_confirm_blink_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pccbs_pkg::PADDR_W-1:0]  paddr,
	input  logic [pccbs_pkg::PDATA_W-1:0]  pwdata,
	output logic [pccbs_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           mode,
	input  logic                           key_target,
	input  logic [pccbs_pkg::COUNT_W-1:0]  press_count,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           led_level,
	output logic                           led_owned,
	output logic                           save_valid,
	output logic                           save_target,
	output logic [pccbs_pkg::COUNT_W-1:0]  save_count
);
	import pccbs_pkg::*;

	cfg_t               cfg;
	result_t            res;
	result_t            res_q;
	logic               valid_s1;
	logic               mode_s1;
	logic               key_target_s1;
	logic [COUNT_W-1:0] press_count_s1;
	logic               result_valid_q;
	logic               advance;
	logic               accept;
	logic               step;

	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign step       = valid_s1 && advance;

	pccbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pccbs_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.mode        (mode_s1),
		.key_target  (key_target_s1),
		.press_count (press_count_s1),
		.cfg         (cfg),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1       <= accept || (valid_s1 && !advance);
			result_valid_q <= step || (result_valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1        <= mode;
			key_target_s1  <= key_target;
			press_count_s1 <= press_count;
		end
		if (step) begin
			res_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign led_level    = res_q.led_level;
	assign led_owned    = res_q.led_owned;
	assign save_valid   = res_q.save_valid;
	assign save_target  = res_q.save_target;
	assign save_count   = res_q.save_count;

endmodule

[test/press_count_confirm_blink_sequencer_checker.sv]
// Checker for the press-count confirm and blink sequencer: predicts and compares each result.
`timescale 1ns / 1ps

module press_count_confirm_blink_sequencer_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [pccbs_pkg::PADDR_W-1:0] paddr,
	input  logic [pccbs_pkg::PDATA_W-1:0] pwdata,
	input  logic                          item_valid,
	input  logic                          item_stall,
	input  logic                          mode,
	input  logic                          key_target,
	input  logic [pccbs_pkg::COUNT_W-1:0] press_count,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic                          led_level,
	input  logic                          led_owned,
	input  logic                          save_valid,
	input  logic                          save_target,
	input  logic [pccbs_pkg::COUNT_W-1:0] save_count,
	output int                            fail_count,
	output int                            outstanding
);
	import pccbs_pkg::*;

	cfg_t               timing;
	logic               setting_armed;
	logic               armed_target;
	logic [COUNT_W-1:0] armed_presses;
	logic [COUNT_W-1:0] blink_count;
	logic               led_lit;
	logic [TICK_W-1:0]  phase_remaining;
	logic [TICK_W-1:0]  confirm_remaining;

	result_t expected_leds[$];
	result_t observed;
	result_t wanted;
	int      mismatches;

	function automatic result_t advance_sequencer(input logic m, input logic tgt,
			input logic [COUNT_W-1:0] presses);
		result_t r;
		r = '0;
		if (m == MODE_KEY) begin
			if (presses >= COUNT_MIN && presses <= COUNT_MAX) begin
				setting_armed     = 1'b1;
				armed_target      = tgt;
				armed_presses     = presses;
				confirm_remaining = timing.confirm_ticks;
				blink_count       = '0;
				led_lit           = 1'b1;
				phase_remaining   = timing.on_ticks;
			end
		end else if (setting_armed) begin
			if (confirm_remaining != '0)
				confirm_remaining = confirm_remaining - 1'b1;
			if (confirm_remaining == '0) begin
				r.save_valid  = 1'b1;
				r.save_target = armed_target;
				r.save_count  = armed_presses;
				setting_armed = 1'b0;
			end else begin
				if (phase_remaining != '0)
					phase_remaining = phase_remaining - 1'b1;
				if (phase_remaining == '0) begin
					if (led_lit) begin
						led_lit         = 1'b0;
						blink_count     = blink_count + 1'b1;
						phase_remaining = timing.off_ticks;
					end else if (blink_count >= armed_presses) begin
						blink_count     = '0;
						phase_remaining = timing.pause_ticks;
					end else begin
						led_lit         = 1'b1;
						phase_remaining = timing.on_ticks;
					end
				end
			end
		end
		r.led_owned = setting_armed;
		r.led_level = (setting_armed && led_lit) ? ~timing.led_off_level : timing.led_off_level;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing.on_ticks      = ON_TICKS_RST;
			timing.off_ticks     = OFF_TICKS_RST;
			timing.pause_ticks   = PAUSE_TICKS_RST;
			timing.confirm_ticks = CONFIRM_TICKS_RST;
			timing.led_off_level = LED_OFF_LEVEL_RST;
			setting_armed        = 1'b0;
			armed_target         = 1'b0;
			armed_presses        = '0;
			blink_count          = '0;
			led_lit              = 1'b0;
			phase_remaining      = '0;
			confirm_remaining    = '0;
			expected_leds.delete();
			mismatches           = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_ON_TICKS:      timing.on_ticks      = pwdata[TICK_W-1:0];
					REG_OFF_TICKS:     timing.off_ticks     = pwdata[TICK_W-1:0];
					REG_PAUSE_TICKS:   timing.pause_ticks   = pwdata[TICK_W-1:0];
					REG_CONFIRM_TICKS: timing.confirm_ticks = pwdata[TICK_W-1:0];
					REG_LED_OFF_LEVEL: timing.led_off_level = pwdata[0];
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				observed.led_level   = led_level;
				observed.led_owned   = led_owned;
				observed.save_valid  = save_valid;
				observed.save_target = save_target;
				observed.save_count  = save_count;
				if (expected_leds.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with no transaction outstanding: %p", $realtime,
							observed);
					mismatches++;
				end else begin
					wanted = expected_leds.pop_front();
					if (observed !== wanted) begin
						if (mismatches < 10)
							$display("%0t: mismatch expected %p actual %p", $realtime,
								wanted, observed);
						mismatches++;
					end
				end
			end
			if (item_valid && !item_stall)
				expected_leds.push_back(advance_sequencer(mode, key_target, press_count));
			fail_count  <= mismatches;
			outstanding <= expected_leds.size();
		end
	end

endmodule

[test/press_count_confirm_blink_sequencer_test.sv]
// Testbench top: stimulus, handshake pressure and verdict for the blink sequencer.
`timescale 1ns / 1ps

module press_count_confirm_blink_sequencer_test;
	import pccbs_pkg::*;

	localparam int LIMIT       = 2000;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_CYCLES = 60;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [PDATA_W-1:0] pwdata       = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               item_valid   = 1'b0;
	logic               item_stall;
	logic               mode         = MODE_TICK;
	logic               key_target   = 1'b0;
	logic [COUNT_W-1:0] press_count  = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               led_level;
	logic               led_owned;
	logic               save_valid;
	logic               save_target;
	logic [COUNT_W-1:0] save_count;

	int   fail_count;
	int   outstanding;
	int   items_sent = 0;
	int   quiet_cycles = 0;
	bit   held = 1'b0;
	logic steady;

	assign steady = items_sent >= 240 && items_sent < 290;

	always #5 clk = ~clk;

	press_count_confirm_blink_sequencer DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall),
		.mode(mode), .key_target(key_target), .press_count(press_count),
		.result_valid(result_valid), .result_stall(result_stall),
		.led_level(led_level), .led_owned(led_owned), .save_valid(save_valid),
		.save_target(save_target), .save_count(save_count)
	);

	press_count_confirm_blink_sequencer_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.item_valid(item_valid), .item_stall(item_stall),
		.mode(mode), .key_target(key_target), .press_count(press_count),
		.result_valid(result_valid), .result_stall(result_stall),
		.led_level(led_level), .led_owned(led_owned), .save_valid(save_valid),
		.save_target(save_target), .save_count(save_count),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(PDATA_W-TICK_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic write_timing(input logic [TICK_W-1:0] on_t, input logic [TICK_W-1:0] off_t,
			input logic [TICK_W-1:0] pause_t, input logic [TICK_W-1:0] confirm_t,
			input logic off_level);
		write_reg(REG_ON_TICKS, on_t);
		write_reg(REG_OFF_TICKS, off_t);
		write_reg(REG_PAUSE_TICKS, pause_t);
		write_reg(REG_CONFIRM_TICKS, confirm_t);
		write_reg(REG_LED_OFF_LEVEL, {{(TICK_W-1){1'b0}}, off_level});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_item(input logic m, input logic tgt, input logic [COUNT_W-1:0] presses);
		while (!steady && $urandom_range(99) < 32) begin
			item_valid  <= 1'b0;
			mode        <= 1'($urandom_range(1));
			press_count <= COUNT_W'($urandom_range(31));
			@(posedge clk);
		end
		item_valid  <= 1'b1;
		mode        <= m;
		key_target  <= tgt;
		press_count <= presses;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic send_ticks(input int count);
		int n;
		for (n = 0; n < count; n++)
			send_item(MODE_TICK, 1'($urandom_range(1)), COUNT_W'($urandom_range(31)));
	endtask

	// drop valid and hold until every result is back
	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic run_presses(input int count, input int key_pct);
		int n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < key_pct) begin
				if ($urandom_range(99) < 85)
					send_item(MODE_KEY, 1'($urandom_range(1)),
						COUNT_W'($urandom_range(int'(COUNT_MAX), int'(COUNT_MIN))));
				else
					send_item(MODE_KEY, 1'($urandom_range(1)),
						COUNT_W'($urandom_range(31)));
			end else begin
				send_item(MODE_TICK, 1'($urandom_range(1)), COUNT_W'($urandom_range(31)));
			end
		end
		drain_results();
	endtask

	initial begin
		int p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(MODE_KEY, 1'b1, 5'd3);
		send_ticks(2);
		drain_results();

		write_timing(16'd1, 16'd2, 16'd1, 16'd6, 1'b1);
		send_ticks(1);
		send_item(MODE_KEY, 1'b0, 5'd0);
		send_item(MODE_KEY, 1'b0, 5'd20);
		send_item(MODE_KEY, 1'b1, 5'd31);
		send_item(MODE_KEY, 1'b1, 5'd19);
		send_ticks(2);
		send_item(MODE_KEY, 1'b0, 5'd1);
		send_ticks(7);
		drain_results();

		write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		run_presses(20, 10);
		write_timing(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
		run_presses(30, 10);
		write_timing(16'd1, 16'd1, 16'd1, 16'd1, 1'b1);
		run_presses(30, 10);

		for (p = 0; p < 6; p++) begin
			write_timing(TICK_W'($urandom_range(4, 1)), TICK_W'($urandom_range(4, 1)),
				TICK_W'($urandom_range(8, 1)), TICK_W'($urandom_range(30, 2)),
				1'($urandom_range(1)));
			run_presses((p == 2) ? 120 : 40, (p % 2 == 0) ? 10 : 4);
		end

		if (fail_count == 0 && outstanding == 0)
			$display("press_count_confirm_blink_sequencer_test passed");
		else
			$display("press_count_confirm_blink_sequencer_test failed");
		$finish;
	end

	initial begin
		int hold;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && items_sent >= HOLD_AT) begin
				held = 1'b1;
				result_stall <= 1'b1;
				for (hold = 0; hold < HOLD_CYCLES; hold++)
					@(posedge clk);
			end else begin
				result_stall <= !steady && ($urandom_range(99) < 32);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(psel && penable && pwrite && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= LIMIT) begin
			$display("press_count_confirm_blink_sequencer_test failed");
			$finish;
		end
	end

endmodule
